// ===== rtl/lkh_pkg.sv =====
package lkh_pkg;

    localparam logic [31:0] HASH_GOLDEN = 32'hdeadbeef;
    localparam logic [31:0] SEED_RESET  = 32'h125df2a7;
    localparam logic [3:0]  BLOCK_BYTES = 4'd12;

    // Register map: byte address bit 2 selects the register word.
    localparam logic REG_SEED = 1'b0;

    // Last step index of the block mix (two rounds a step) and of the final mix.
    localparam logic [1:0] MIX_LAST_STEP = 2'd2;
    localparam logic [1:0] FIN_LAST_STEP = 2'd3;

    typedef struct packed {
        logic [31:0] w_low;
        logic [31:0] w_mid;
        logic [31:0] w_high;
        logic [31:0] init_val;
        logic        first;
        logic        last;
        logic        empty;
    } t_blk;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } t_abc;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MIX,
        BK_FIN,
        BK_EMIT
    } t_bk_state;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned k);
        return (x << k) | (x >> (32 - k));
    endfunction

    // Keep the low n bytes (0 to 4) of a word.
    function automatic logic [31:0] keep_bytes(input logic [31:0] w, input logic [2:0] n);
        logic [31:0] r;
        case (n)
            3'd0: r = 32'h0;
            3'd1: r = w & 32'h0000_00ff;
            3'd2: r = w & 32'h0000_ffff;
            3'd3: r = w & 32'h00ff_ffff;
            default: r = w;
        endcase
        return r;
    endfunction

    // Two rounds of the block mix per step.
    function automatic t_abc blk_step(input t_abc s, input logic [1:0] step);
        t_abc r;
        r = s;
        case (step)
            2'd0: begin
                r.a = (r.a - r.c) ^ rotl32(r.c, 4);
                r.c = r.c + r.b;
                r.b = (r.b - r.a) ^ rotl32(r.a, 6);
                r.a = r.a + r.c;
            end
            2'd1: begin
                r.c = (r.c - r.b) ^ rotl32(r.b, 8);
                r.b = r.b + r.a;
                r.a = (r.a - r.c) ^ rotl32(r.c, 16);
                r.c = r.c + r.b;
            end
            2'd2: begin
                r.b = (r.b - r.a) ^ rotl32(r.a, 19);
                r.a = r.a + r.c;
                r.c = (r.c - r.b) ^ rotl32(r.b, 4);
                r.b = r.b + r.a;
            end
            default: r = s;
        endcase
        return r;
    endfunction

    // Two rounds of the final mix per step, the seventh round alone.
    function automatic t_abc fin_step(input t_abc s, input logic [1:0] step);
        t_abc r;
        r = s;
        case (step)
            2'd0: begin
                r.c = (r.c ^ r.b) - rotl32(r.b, 14);
                r.a = (r.a ^ r.c) - rotl32(r.c, 11);
            end
            2'd1: begin
                r.b = (r.b ^ r.a) - rotl32(r.a, 25);
                r.c = (r.c ^ r.b) - rotl32(r.b, 16);
            end
            2'd2: begin
                r.a = (r.a ^ r.c) - rotl32(r.c, 4);
                r.b = (r.b ^ r.a) - rotl32(r.a, 14);
            end
            default: begin
                r.c = (r.c ^ r.b) - rotl32(r.b, 24);
            end
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/lkh_front.sv =====
module lkh_front (
    input  logic [31:0]       i_word_low,
    input  logic [31:0]       i_word_mid,
    input  logic [31:0]       i_word_high,
    input  logic [3:0]        i_block_bytes,
    input  logic              i_first_block,
    input  logic              i_last_block,
    input  logic [15:0]       i_key_length,
    input  logic [31:0]       i_seed,
    output lkh_pkg::t_blk     o_blk
);

    logic [3:0] nb;
    logic [2:0] n_low;
    logic [2:0] n_mid;
    logic [2:0] n_high;

    always_comb begin
        nb = (i_block_bytes > lkh_pkg::BLOCK_BYTES) ? lkh_pkg::BLOCK_BYTES : i_block_bytes;

        n_low  = (nb >= 4'd4)  ? 3'd4 : nb[2:0];
        n_mid  = (nb >= 4'd8)  ? 3'd4 : (nb > 4'd4) ? 3'(nb - 4'd4) : 3'd0;
        n_high = (nb >= 4'd12) ? 3'd4 : (nb > 4'd8) ? 3'(nb - 4'd8) : 3'd0;

        // Only the last block is trimmed to its valid bytes.
        if (i_last_block) begin
            o_blk.w_low  = lkh_pkg::keep_bytes(i_word_low, n_low);
            o_blk.w_mid  = lkh_pkg::keep_bytes(i_word_mid, n_mid);
            o_blk.w_high = lkh_pkg::keep_bytes(i_word_high, n_high);
        end else begin
            o_blk.w_low  = i_word_low;
            o_blk.w_mid  = i_word_mid;
            o_blk.w_high = i_word_high;
        end

        o_blk.init_val = lkh_pkg::HASH_GOLDEN + {14'd0, i_key_length, 2'b00} + i_seed;
        o_blk.first    = i_first_block;
        o_blk.last     = i_last_block;
        o_blk.empty    = i_last_block && (i_block_bytes == 4'd0);
    end

endmodule

// ===== rtl/lkh_queue.sv =====
module lkh_queue #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lkh_pkg::t_blk     i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_pop,
    output lkh_pkg::t_blk     o_data
);

    localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    lkh_pkg::t_blk    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wptr;
    logic [PTR_W-1:0] n_rptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue popped while empty");

endmodule

// ===== rtl/lkh_back.sv =====
module lkh_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  lkh_pkg::t_blk     i_blk,
    output logic              o_take,
    output logic              o_out_valid,
    output logic [31:0]       o_hash,
    input  logic              i_out_pop
);

    lkh_pkg::t_bk_state r_state;
    lkh_pkg::t_bk_state n_state;
    logic [1:0]         r_step;
    logic [1:0]         n_step;
    lkh_pkg::t_abc      r_abc;
    lkh_pkg::t_abc      n_abc;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [31:0]        r_hash;
    logic [31:0]        n_hash;
    logic               out_free;
    logic               out_load;
    lkh_pkg::t_abc      base;
    lkh_pkg::t_abc      fin_res;

    assign out_free = !r_out_valid || i_out_pop;

    // Next state.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            lkh_pkg::BK_IDLE: begin
                n_step = 2'd0;
                if (i_valid) begin
                    if (i_blk.empty) begin
                        n_state = lkh_pkg::BK_EMIT;
                    end else if (i_blk.last) begin
                        n_state = lkh_pkg::BK_FIN;
                    end else begin
                        n_state = lkh_pkg::BK_MIX;
                    end
                end
            end
            lkh_pkg::BK_MIX: begin
                if (r_step == lkh_pkg::MIX_LAST_STEP) begin
                    n_state = lkh_pkg::BK_IDLE;
                    n_step  = 2'd0;
                end else begin
                    n_step = r_step + 2'd1;
                end
            end
            lkh_pkg::BK_FIN: begin
                if (r_step == lkh_pkg::FIN_LAST_STEP) begin
                    if (out_free) begin
                        n_state = lkh_pkg::BK_IDLE;
                        n_step  = 2'd0;
                    end
                end else begin
                    n_step = r_step + 2'd1;
                end
            end
            lkh_pkg::BK_EMIT: begin
                if (out_free) begin
                    n_state = lkh_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = lkh_pkg::BK_IDLE;
                n_step  = 2'd0;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        o_take   = 1'b0;
        out_load = 1'b0;
        n_abc    = r_abc;
        n_hash   = r_hash;
        base     = r_abc;
        if (i_blk.first) begin
            base.a = i_blk.init_val;
            base.b = i_blk.init_val;
            base.c = i_blk.init_val;
        end
        fin_res  = lkh_pkg::fin_step(r_abc, r_step);
        case (r_state)
            lkh_pkg::BK_IDLE: begin
                o_take = i_valid;
                if (i_valid) begin
                    n_abc.a = base.a + i_blk.w_low;
                    n_abc.b = base.b + i_blk.w_mid;
                    n_abc.c = base.c + i_blk.w_high;
                end
            end
            lkh_pkg::BK_MIX: begin
                n_abc = lkh_pkg::blk_step(r_abc, r_step);
            end
            lkh_pkg::BK_FIN: begin
                // The last round waits here until the result register is free.
                if (r_step != lkh_pkg::FIN_LAST_STEP || out_free) begin
                    n_abc = fin_res;
                end
                if (r_step == lkh_pkg::FIN_LAST_STEP && out_free) begin
                    out_load = 1'b1;
                    n_hash   = fin_res.c;
                end
            end
            lkh_pkg::BK_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_hash   = r_abc.c;
                end
            end
            default: begin
                n_abc = r_abc;
            end
        endcase
        n_out_valid = out_load ? 1'b1 : (i_out_pop ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lkh_pkg::BK_IDLE;
            r_step      <= 2'd0;
            r_abc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_abc       <= n_abc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hash <= n_hash;
    end

    assign o_out_valid = r_out_valid;
    assign o_hash      = r_hash;

    a_mix_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lkh_pkg::BK_MIX |-> r_step <= lkh_pkg::MIX_LAST_STEP)
        else $error("block mix step out of range");

    a_take_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> r_state == lkh_pkg::BK_IDLE)
        else $error("block taken while busy");

    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_valid && r_state == lkh_pkg::BK_IDLE)
        else $error("result load did not register");

endmodule

// ===== rtl/lookup3_key_hash_core.sv =====
// lookup3 32-bit key hash.
// Blocks of a key enter through a queue-like port: drive the three words,
// block_bytes, first_block, last_block and key_length with push high; the
// block is taken at an edge where full is low. The first block of a key
// carries the total length and loads the start state from the seed register.
// Results leave through a queue-like port: hash_value is valid while empty is
// low and is taken at an edge where pop is high.
// Blocks wait in a small queue in front of the mixing engine, so the sender
// keeps pushing while the engine works or a result is held by the receiver.
// For a non-last block the engine adds the three words and then runs the block
// mix, two rounds a step; for a last block it adds the trimmed words and runs
// the final mix; for an empty key it passes the state word c out unmixed.
// One result register holds the hash; if it is still full when the next hash
// is ready, the engine stalls and the input queue fills, raising full.
// Reset (synchronous, active low) empties the queue and result register, clears
// the mix state and loads the seed register with 0x125df2a7. The seed is
// written through the APB port at byte address 0; the user must write it only
// while the block is idle, as the block itself does not enforce this.
module lookup3_key_hash_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_word_low,
    input  logic [31:0] i_word_mid,
    input  logic [31:0] i_word_high,
    input  logic [3:0]  i_block_bytes,
    input  logic        i_first_block,
    input  logic        i_last_block,
    input  logic [15:0] i_key_length,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_hash_value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0]   r_seed;
    lkh_pkg::t_blk front_blk;
    lkh_pkg::t_blk queue_blk;
    logic          q_full;
    logic          q_valid;
    logic          bk_take;
    logic          out_valid;
    logic          in_push;
    logic          out_pop;
    logic          seed_sel;

    assign pready   = 1'b1;
    assign seed_sel = (paddr[2] == lkh_pkg::REG_SEED);
    assign prdata   = seed_sel ? r_seed : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= lkh_pkg::SEED_RESET;
        end else if (psel && penable && pwrite && pready && seed_sel) begin
            r_seed <= pwdata;
        end
    end

    assign in_push = push && !q_full;
    assign full    = q_full;
    assign empty   = !out_valid;
    assign out_pop = pop && out_valid;

    lkh_front u_front (
        .i_word_low    (i_word_low),
        .i_word_mid    (i_word_mid),
        .i_word_high   (i_word_high),
        .i_block_bytes (i_block_bytes),
        .i_first_block (i_first_block),
        .i_last_block  (i_last_block),
        .i_key_length  (i_key_length),
        .i_seed        (r_seed),
        .o_blk         (front_blk)
    );

    lkh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_push),
        .i_data  (front_blk),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (bk_take),
        .o_data  (queue_blk)
    );

    lkh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_blk       (queue_blk),
        .o_take      (bk_take),
        .o_out_valid (out_valid),
        .o_hash      (o_hash_value),
        .i_out_pop   (out_pop)
    );

endmodule

// ===== bench/lookup3_key_hash_core_tb.sv =====
module lookup3_key_hash_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES  = 40;
    localparam int STALL_LIMIT    = 2000;
    localparam int PHASE_ITEMS    = 510;

    typedef struct packed {
        logic [31:0] w_low;
        logic [31:0] w_mid;
        logic [31:0] w_high;
        logic [3:0]  nbytes;
        logic        first;
        logic        last;
        logic [15:0] klen;
    } t_key_block;

    typedef struct {
        t_key_block  blk;
        bit          typed;
        logic [31:0] want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [31:0] i_word_low = '0;
    logic [31:0] i_word_mid = '0;
    logic [31:0] i_word_high = '0;
    logic [3:0]  i_block_bytes = '0;
    logic        i_first_block = 1'b0;
    logic        i_last_block = 1'b0;
    logic [15:0] i_key_length = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] o_hash_value;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Shadow of the hash engine and its seed register.
    logic [31:0] st_a = '0;
    logic [31:0] st_b = '0;
    logic [31:0] st_c = '0;
    logic [31:0] seed_copy = lkh_pkg::SEED_RESET;

    logic [31:0] hash_expect_q[$];
    t_dir_row    dir_tab[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int          blocks_sent = 0;
    int          mismatches = 0;
    int          stall_cycles = 0;

    lookup3_key_hash_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_word_low    (i_word_low),
        .i_word_mid    (i_word_mid),
        .i_word_high   (i_word_high),
        .i_block_bytes (i_block_bytes),
        .i_first_block (i_first_block),
        .i_last_block  (i_last_block),
        .i_key_length  (i_key_length),
        .empty         (empty),
        .pop           (pop),
        .o_hash_value  (o_hash_value),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rol(input logic [31:0] x, input int k);
        return (x << k) | (x >> (32 - k));
    endfunction

    function automatic logic [31:0] low_bytes(input logic [31:0] w, input int n);
        if (n >= 4)
            return w;
        return w & ((32'h1 << (8 * n)) - 32'h1);
    endfunction

    function automatic void churn();
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        a = st_a; b = st_b; c = st_c;
        a -= c; a ^= rol(c, 4);  c += b;
        b -= a; b ^= rol(a, 6);  a += c;
        c -= b; c ^= rol(b, 8);  b += a;
        a -= c; a ^= rol(c, 16); c += b;
        b -= a; b ^= rol(a, 19); a += c;
        c -= b; c ^= rol(b, 4);  b += a;
        st_a = a; st_b = b; st_c = c;
    endfunction

    function automatic void finalize();
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        a = st_a; b = st_b; c = st_c;
        c ^= b; c -= rol(b, 14);
        a ^= c; a -= rol(c, 11);
        b ^= a; b -= rol(a, 25);
        c ^= b; c -= rol(b, 16);
        a ^= c; a -= rol(c, 4);
        b ^= a; b -= rol(a, 14);
        c ^= b; c -= rol(b, 24);
        st_a = a; st_b = b; st_c = c;
    endfunction

    // Folds one block into the shadow state; a last block yields the hash.
    function automatic void absorb(input t_key_block blk, output bit emits,
                                   output logic [31:0] hv);
        logic [31:0] init;
        int          n;
        emits = 1'b0;
        hv = '0;
        if (blk.first) begin
            init = lkh_pkg::HASH_GOLDEN + {14'd0, blk.klen, 2'b00} + seed_copy;
            st_a = init;
            st_b = init;
            st_c = init;
        end
        if (!blk.last) begin
            st_a += blk.w_low;
            st_b += blk.w_mid;
            st_c += blk.w_high;
            churn();
            return;
        end
        n = (blk.nbytes > lkh_pkg::BLOCK_BYTES) ? int'(lkh_pkg::BLOCK_BYTES)
                                                : int'(blk.nbytes);
        emits = 1'b1;
        if (n == 0) begin
            hv = st_c;
            return;
        end
        st_a += low_bytes(blk.w_low, n);
        if (n > 4)
            st_b += low_bytes(blk.w_mid, n - 4);
        if (n > 8)
            st_c += low_bytes(blk.w_high, n - 8);
        finalize();
        hv = st_c;
    endfunction

    function automatic t_dir_row mk_row(input logic [31:0] lo, input logic [31:0] mid,
                                        input logic [31:0] hi, input logic [3:0] nb,
                                        input bit f, input bit l, input logic [15:0] kl,
                                        input bit typed = 1'b0,
                                        input logic [31:0] want = '0);
        t_dir_row r;
        r.blk = '{w_low: lo, w_mid: mid, w_high: hi, nbytes: nb, first: f, last: l,
                  klen: kl};
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_block(input t_key_block blk, input bit typed,
                              input logic [31:0] want);
        bit          emits;
        logic [31:0] hv;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push          <= 1'b1;
        i_word_low    <= blk.w_low;
        i_word_mid    <= blk.w_mid;
        i_word_high   <= blk.w_high;
        i_block_bytes <= blk.nbytes;
        i_first_block <= blk.first;
        i_last_block  <= blk.last;
        i_key_length  <= blk.klen;
        forever begin
            @(posedge i_clk);
            if (!full)
                break;
        end
        absorb(blk, emits, hv);
        if (emits)
            hash_expect_q.push_back(typed ? want : hv);
        blocks_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_key(input int len);
        int         nblk;
        t_key_block blk;
        nblk = (len == 0) ? 1 : (len + 11) / 12;
        for (int i = 0; i < nblk; i++) begin
            blk.w_low  = $urandom;
            blk.w_mid  = $urandom;
            blk.w_high = $urandom;
            blk.first  = (i == 0);
            blk.last   = (i == nblk - 1);
            blk.klen   = len[15:0];
            blk.nbytes = blk.last ? 4'(len - 12 * i) : lkh_pkg::BLOCK_BYTES;
            send_block(blk, 1'b0, '0);
        end
    endtask

    // A block with every field random: stray starts, missing starts, bad counts.
    task automatic send_noise();
        t_key_block blk;
        blk.w_low  = $urandom;
        blk.w_mid  = $urandom;
        blk.w_high = $urandom;
        blk.nbytes = 4'($urandom_range(15));
        blk.first  = 1'($urandom_range(1));
        blk.last   = 1'($urandom_range(1));
        blk.klen   = 16'($urandom);
        send_block(blk, 1'b0, '0);
    endtask

    task automatic run_phase(input int unsigned s_pct, input int unsigned r_pct);
        int goal;
        int pick;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        goal = blocks_sent + PHASE_ITEMS;
        while (blocks_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 15)
                send_noise();
            else if (pick < 75)
                send_key($urandom_range(36));
            else if (pick < 96)
                send_key($urandom_range(200, 37));
            else
                send_key($urandom_range(600, 201));
        end
    endtask

    // Called at a falling edge; lets the engine finish blocks that emit nothing.
    task automatic drain();
        push <= 1'b0;
        while (hash_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apb_xfer(input bit wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {lkh_pkg::REG_SEED, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready)
                break;
        end
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_seed(input logic [31:0] value);
        logic [31:0] rd;
        apb_xfer(1'b1, value, rd);
        seed_copy = value;
        @(negedge i_clk);
        apb_xfer(1'b0, '0, rd);
        if (rd !== value)
            note_mismatch("seed readback", rd, value);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk)
        pop <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (hash_expect_q.size() == 0)
                    note_mismatch("unexpected hash", o_hash_value, 'x);
                else if (o_hash_value !== hash_expect_q[0])
                    note_mismatch("hash_value", o_hash_value, hash_expect_q[0]);
                if (hash_expect_q.size() != 0)
                    void'(hash_expect_q.pop_front());
            end
            if ((push && !full) || (pop && !empty))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[lookup3_key_hash_core] ERROR");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] rd;

        // Empty keys right after reset, then boundary byte counts and key shapes.
        dir_tab.push_back(mk_row('0, '0, '0, 4'd0, 1'b0, 1'b1, 16'd0, 1'b1, 32'h0));
        dir_tab.push_back(mk_row('0, '0, '0, 4'd0, 1'b1, 1'b1, 16'd0, 1'b1, 32'hf10bb196));
        dir_tab.push_back(mk_row('1, '1, '1, 4'd0, 1'b1, 1'b1, 16'hffff, 1'b1,
                                 32'hf10fb192));
        dir_tab.push_back(mk_row('1, '1, '1, 4'd1, 1'b1, 1'b1, 16'd1));
        dir_tab.push_back(mk_row('1, '1, '1, 4'd12, 1'b1, 1'b1, 16'd12));
        dir_tab.push_back(mk_row('0, '0, '0, 4'd12, 1'b1, 1'b1, 16'd12));
        dir_tab.push_back(mk_row('1, '1, '1, 4'd15, 1'b1, 1'b1, 16'd12));
        dir_tab.push_back(mk_row(32'h01234567, 32'h89abcdef, 32'hfedcba98, 4'd13,
                                 1'b1, 1'b1, 16'd12));
        dir_tab.push_back(mk_row(32'h03020100, 32'h07060504, 32'h0b0a0908, 4'd12,
                                 1'b1, 1'b0, 16'd24));
        dir_tab.push_back(mk_row(32'h0f0e0d0c, 32'h13121110, 32'h17161514, 4'd12,
                                 1'b0, 1'b1, 16'd24));
        dir_tab.push_back(mk_row(32'h6c6c6568, 32'h6f77206f, 32'h20646c72, 4'd12,
                                 1'b1, 1'b0, 16'd29));
        dir_tab.push_back(mk_row(32'hdeadbeef, 32'hcafef00d, 32'h8badf00d, 4'd12,
                                 1'b0, 1'b0, 16'd29));
        dir_tab.push_back(mk_row(32'h11223344, 32'h55667788, 32'h99aabbcc, 4'd5,
                                 1'b0, 1'b1, 16'd29));
        // A key that never got its start block runs on the finalized state.
        dir_tab.push_back(mk_row(32'h80000001, 32'h7ffffffe, 32'h00ff00ff, 4'd12,
                                 1'b0, 1'b0, 16'd16));
        dir_tab.push_back(mk_row(32'h12345678, 32'h9abcdef0, 32'h0f1e2d3c, 4'd4,
                                 1'b0, 1'b1, 16'd16));
        // A short count on a non-last block still adds all three words.
        dir_tab.push_back(mk_row('1, '1, '1, 4'd3, 1'b1, 1'b0, 16'd20));
        dir_tab.push_back(mk_row(32'ha5a5a5a5, 32'h5a5a5a5a, 32'hc3c3c3c3, 4'd8,
                                 1'b0, 1'b1, 16'd20));
        dir_tab.push_back(mk_row(32'h76543210, 32'hfedcba98, 32'h33333333, 4'd12,
                                 1'b1, 1'b0, 16'd12));
        dir_tab.push_back(mk_row('1, '1, '1, 4'd0, 1'b0, 1'b1, 16'd12));
        dir_tab.push_back(mk_row(32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 4'd12,
                                 1'b1, 1'b1, 16'hffff));
        dir_tab.push_back(mk_row('1, '1, '1, 4'd4, 1'b1, 1'b1, 16'd4));
        dir_tab.push_back(mk_row('1, '1, '1, 4'd5, 1'b1, 1'b1, 16'd5));
        dir_tab.push_back(mk_row('1, '1, '1, 4'd8, 1'b1, 1'b1, 16'd8));
        dir_tab.push_back(mk_row('1, '1, '1, 4'd9, 1'b1, 1'b1, 16'd9));
        dir_tab.push_back(mk_row('1, '1, '1, 4'd11, 1'b1, 1'b1, 16'd11));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        apb_xfer(1'b0, '0, rd);
        if (rd !== lkh_pkg::SEED_RESET)
            note_mismatch("seed after reset", rd, lkh_pkg::SEED_RESET);
        @(negedge i_clk);

        foreach (dir_tab[i])
            send_block(dir_tab[i].blk, dir_tab[i].typed, dir_tab[i].want);
        drain();

        load_seed(32'hffffffff);
        run_phase(16, 56);
        drain();

        load_seed(32'h0);
        run_phase(56, 16);
        drain();

        load_seed($urandom);
        run_phase(0, 0);
        drain();

        if (mismatches == 0)
            $display("[lookup3_key_hash_core] OK");
        else
            $display("[lookup3_key_hash_core] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lkh_pkg.sv
rtl/lkh_front.sv
rtl/lkh_queue.sv
rtl/lkh_back.sv
rtl/lookup3_key_hash_core.sv
bench/lookup3_key_hash_core_tb.sv
